// ===== rtl/core/tilt_balance_pid_controller_core_assert.svh =====
// Assertion macros shared by the tilt balance controller RTL.
`ifndef TILT_BALANCE_PID_CONTROLLER_CORE_ASSERT_SVH
`define TILT_BALANCE_PID_CONTROLLER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define TBP_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define TBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define TBP_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define TBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/core/tbp_pkg.sv =====
// Types, constants and tables of the tilt balance controller.
`default_nettype none
package tbp_pkg;
	localparam int OP_W = 5;
	localparam logic [OP_W-1:0] OP_IDLE  = 5'd0;
	localparam logic [OP_W-1:0] OP_PRE   = 5'd1;
	localparam logic [OP_W-1:0] OP_CORD  = 5'd2;
	localparam logic [OP_W-1:0] OP_ACC   = 5'd3;
	localparam logic [OP_W-1:0] OP_SDIV  = 5'd4;
	localparam logic [OP_W-1:0] OP_SWAIT = 5'd5;
	localparam logic [OP_W-1:0] OP_STEP  = 5'd6;
	localparam logic [OP_W-1:0] OP_FDIV  = 5'd7;
	localparam logic [OP_W-1:0] OP_FWAIT = 5'd8;
	localparam logic [OP_W-1:0] OP_TILT  = 5'd9;
	localparam logic [OP_W-1:0] OP_ERR   = 5'd10;
	localparam logic [OP_W-1:0] OP_M1    = 5'd11;
	localparam logic [OP_W-1:0] OP_M2    = 5'd12;
	localparam logic [OP_W-1:0] OP_M3    = 5'd13;
	localparam logic [OP_W-1:0] OP_M4    = 5'd14;
	localparam logic [OP_W-1:0] OP_M5    = 5'd15;
	localparam logic [OP_W-1:0] OP_M6    = 5'd16;
	localparam logic [OP_W-1:0] OP_M7    = 5'd17;
	localparam logic [OP_W-1:0] OP_M8    = 5'd18;
	localparam logic [OP_W-1:0] OP_DDIV  = 5'd19;
	localparam logic [OP_W-1:0] OP_DWAIT = 5'd20;
	localparam logic [OP_W-1:0] OP_FIN   = 5'd21;

	localparam int ITER_W = 5;

	localparam logic [1:0] CFG_GAIN_PROP   = 2'd0;
	localparam logic [1:0] CFG_GAIN_INTEG  = 2'd1;
	localparam logic [1:0] CFG_GAIN_DERIV  = 2'd2;
	localparam logic [1:0] CFG_TARGET_TILT = 2'd3;

	localparam logic [1:0] DIR_STOP = 2'd0;
	localparam logic [1:0] DIR_FWD  = 2'd1;
	localparam logic [1:0] DIR_BACK = 2'd2;

	localparam int TILT_LIM  = 46080;
	localparam int SUM_LIM   = 25600000;
	localparam int RANGE_LIM = 7680;
	localparam int STOP_LEVEL = 10;
	localparam logic [7:0] SPEED_MAX = 8'd255;
	localparam int K_MILLI = 1000;
	localparam int K_MEGA  = 1000000;
	localparam logic signed [25:0] Z_QUARTER = 26'sd5898240;

	// divider: drive quotient bits, rounding offsets, reciprocals of the fixed divisors
	localparam int DV_W = 56;
	localparam int QW   = 19;
	localparam int DRV_QBITS  = 8;
	localparam int RCP_CYCLES = 2;
	localparam logic [DV_W-1:0] STEP_HALF = 56'd65500;
	localparam logic [DV_W-1:0] FILT_HALF = 56'd25;
	localparam int STEP_RSH = 34;
	localparam int FILT_RSH = 23;
	localparam logic [17:0] STEP_DIV = 18'd131000;
	localparam logic [17:0] FILT_DIV = 18'd50;
	localparam logic [17:0] STEP_RCP = 18'((64'd1 << STEP_RSH) / 64'd131000);
	localparam logic [17:0] FILT_RCP = 18'((64'd1 << FILT_RSH) / 64'd50);

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [ITER_W-1:0] iter;
	} tbp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_busy;
	} tbp_stat_t;

	// arctangent of 2^-i in 1/65536 degree
	function automatic logic [21:0] atan_entry(input logic [ITER_W-1:0] i);
		logic [21:0] v;
		unique case (i)
			5'd0:  v = 22'd2949120;
			5'd1:  v = 22'd1740967;
			5'd2:  v = 22'd919879;
			5'd3:  v = 22'd466945;
			5'd4:  v = 22'd234379;
			5'd5:  v = 22'd117304;
			5'd6:  v = 22'd58666;
			5'd7:  v = 22'd29335;
			5'd8:  v = 22'd14668;
			5'd9:  v = 22'd7334;
			5'd10: v = 22'd3667;
			5'd11: v = 22'd1833;
			5'd12: v = 22'd917;
			5'd13: v = 22'd458;
			5'd14: v = 22'd229;
			5'd15: v = 22'd115;
			5'd16: v = 22'd57;
			5'd17: v = 22'd29;
			5'd18: v = 22'd14;
			5'd19: v = 22'd7;
			5'd20: v = 22'd4;
			5'd21: v = 22'd2;
			5'd22: v = 22'd1;
			default: v = 22'd0;
		endcase
		return v;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/core/tbp_if.sv =====
// Request channels of the tilt balance controller: sample, result and config.
`default_nettype none
interface tbp_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_z;
	logic signed [15:0] gyro_y;
	logic [9:0]         elapsed_ms;
	modport source (output valid, accel_x, accel_z, gyro_y, elapsed_ms, input ready);
	modport sink (input valid, accel_x, accel_z, gyro_y, elapsed_ms, output ready);
endinterface

interface tbp_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         drive_dir;
	logic [7:0]         drive_speed;
	logic signed [16:0] tilt_angle;
	modport source (output valid, drive_dir, drive_speed, tilt_angle, input ready);
	modport sink (input valid, drive_dir, drive_speed, tilt_angle, output ready);
endinterface

interface tbp_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  addr;
	logic [16:0] data;
	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/tbp_ctrl.sv =====
// Sequencer of the tilt balance controller.
`default_nettype none
`include "tilt_balance_pid_controller_core_assert.svh"
module tbp_ctrl #(
	parameter int ATAN_ITERATIONS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  tbp_pkg::tbp_stat_t stat,
	output tbp_pkg::tbp_cmd_t  cmd
);
	import tbp_pkg::*;

	localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(ATAN_ITERATIONS - 1);

	logic [OP_W-1:0]   state_q, state_d;
	logic [ITER_W-1:0] iter_q, iter_d;

	always_comb begin
		state_d = state_q;
		iter_d  = iter_q;
		unique case (state_q)
			OP_IDLE: if (in_valid) state_d = OP_PRE;
			OP_PRE: begin
				state_d = OP_CORD;
				iter_d  = '0;
			end
			OP_CORD: begin
				if (iter_q == ITER_LAST) state_d = OP_ACC;
				else iter_d = iter_q + 1'b1;
			end
			OP_ACC:   state_d = OP_SDIV;
			OP_SDIV:  state_d = OP_SWAIT;
			OP_SWAIT: if (stat.div_done) state_d = OP_STEP;
			OP_STEP:  state_d = OP_FDIV;
			OP_FDIV:  state_d = OP_FWAIT;
			OP_FWAIT: if (stat.div_done) state_d = OP_TILT;
			OP_TILT:  state_d = OP_ERR;
			OP_ERR:   state_d = OP_M1;
			OP_M1:    state_d = OP_M2;
			OP_M2:    state_d = OP_M3;
			OP_M3:    state_d = OP_M4;
			OP_M4:    state_d = OP_M5;
			OP_M5:    state_d = OP_M6;
			OP_M6:    state_d = OP_M7;
			OP_M7:    state_d = OP_M8;
			OP_M8:    state_d = OP_DDIV;
			OP_DDIV:  state_d = OP_DWAIT;
			OP_DWAIT: if (stat.div_done) state_d = OP_FIN;
			OP_FIN:   if (!stat.out_busy) state_d = OP_IDLE;
			default:  state_d = OP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= OP_IDLE;
			iter_q  <= '0;
		end else begin
			state_q <= state_d;
			iter_q  <= iter_d;
		end
	end

	assign cmd.op   = state_q;
	assign cmd.iter = iter_q;

	`TBP_ASSERT_NEXT(a_cord_len, clk, arst_n, state_q == OP_CORD && iter_q != ITER_LAST, state_q == OP_CORD, "cordic left early")
	`TBP_ASSERT_NEXT(a_fin_hold, clk, arst_n, state_q == OP_FIN && stat.out_busy, state_q == OP_FIN, "result overwritten")
	`TBP_ASSERT_NEXT(a_div_wait, clk, arst_n, (state_q == OP_SWAIT || state_q == OP_FWAIT || state_q == OP_DWAIT) && !stat.div_done, state_q == $past(state_q), "divider not finished")
endmodule
`default_nettype wire

// ===== rtl/core/tbp_datapath.sv =====
// Datapath: cordic, shared multiplier, shared divider, filter and PID state.
`default_nettype none
`include "tilt_balance_pid_controller_core_assert.svh"
module tbp_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  tbp_pkg::tbp_cmd_t  cmd,
	output tbp_pkg::tbp_stat_t stat,
	tbp_in_if.sink             sample,
	tbp_out_if.source          result,
	tbp_cfg_if.sink            cfg
);
	import tbp_pkg::*;

	logic [15:0]        gp_q, gi_q, gd_q;
	logic signed [16:0] tgt_q;

	logic signed [15:0] ax_q, az_q, gy_q;
	logic [9:0]         ms_q;
	logic [19:0]        kms_q;
	logic signed [35:0] x_q, y_q;
	logic signed [25:0] z_q;
	logic               zero_q;
	logic signed [17:0] acc_q, step_q, err_q, lerr_q;
	logic signed [16:0] tilt_q, tilt_est_q;
	logic signed [18:0] diff_q;
	logic signed [25:0] sum_q, esum_q;
	logic signed [57:0] prod_q;
	logic signed [56:0] num_q;
	logic               sign_q, sat_q;
	logic [DV_W-1:0]    rem_q, dsh_q;
	logic [QW-1:0]      quo_q;
	logic [4:0]         dcnt_q;
	logic               rdiv_q, rfilt_q;
	logic               res_valid_q;
	logic [1:0]         dir_q;
	logic [7:0]         speed_q;
	logic signed [16:0] angle_q;

	logic               accept;
	logic signed [43:0] mul_a;
	logic signed [21:0] mul_b;
	logic signed [65:0] mul_p;
	logic signed [35:0] x0, y0, xs, ys;
	logic signed [25:0] zt;
	logic signed [17:0] acc_r;
	logic signed [57:0] pmag;
	logic [DV_W-1:0]    nstep, nfilt, nmag;
	logic signed [18:0] fsum;
	logic signed [26:0] fnum, fmag;
	logic [17:0]        rcp_sel, dv_sel;
	logic [51:0]        rprod;
	logic [QW-1:0]      rq, quo_c;
	logic [36:0]        rsub;
	logic               rup;
	logic signed [19:0] qs;
	logic signed [16:0] tilt_c;
	logic signed [29:0] sacc;
	logic signed [25:0] sum_c;
	logic signed [56:0] amag;
	logic               sat_c, low_drive, in_range;

	assign accept = sample.valid && sample.ready;
	assign sample.ready = (cmd.op == OP_IDLE);
	assign cfg.ready = 1'b1;

	// shared multiplier, operands chosen by step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			OP_ACC: begin mul_a = 44'(gy_q);  mul_b = $signed({12'd0, ms_q}); end
			OP_M1:  begin mul_a = 44'(err_q); mul_b = $signed({12'd0, ms_q}); end
			OP_M2:  begin mul_a = 44'(err_q); mul_b = $signed({6'd0, gp_q}); end
			OP_M3:  begin mul_a = prod_q[43:0]; mul_b = $signed({2'd0, kms_q}); end
			OP_M4:  begin mul_a = 44'(sum_q); mul_b = $signed({6'd0, gi_q}); end
			OP_M5:  begin mul_a = prod_q[43:0]; mul_b = $signed({12'd0, ms_q}); end
			OP_M6:  begin mul_a = 44'(diff_q); mul_b = $signed({6'd0, gd_q}); end
			OP_M7:  begin mul_a = prod_q[43:0]; mul_b = 22'(K_MEGA); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// cordic
	assign x0 = $signed({{4{az_q[15]}}, az_q, 16'd0});
	assign y0 = -$signed({{4{ax_q[15]}}, ax_q, 16'd0});
	assign xs = x_q >>> cmd.iter;
	assign ys = y_q >>> cmd.iter;
	assign zt = $signed({4'd0, atan_entry(cmd.iter)});
	always_comb begin
		if (z_q >= 0) acc_r = 18'((z_q + 26'sd128) >>> 8);
		else acc_r = -18'((-z_q + 26'sd128) >>> 8);
	end

	// divider operands
	assign pmag  = prod_q[57] ? -prod_q : prod_q;
	assign nstep = {pmag[47:0], 8'd0} + STEP_HALF;
	assign fsum  = 19'(tilt_est_q) + 19'(step_q);
	assign fnum  = 27'(fsum) * 27'sd49 + 27'(acc_q);
	assign fmag  = fnum[26] ? -fnum : fnum;
	assign nfilt = DV_W'(fmag) + FILT_HALF;
	assign amag  = num_q[56] ? -num_q : num_q;
	assign nmag  = DV_W'(amag);
	assign sat_c = nmag >= DV_W'({kms_q, 24'd0});

	// fixed divisors: reciprocal estimate is exact or one short, remainder fixes it
	assign rcp_sel = rfilt_q ? FILT_RCP : STEP_RCP;
	assign dv_sel  = rfilt_q ? FILT_DIV : STEP_DIV;
	assign rprod   = rem_q[33:0] * rcp_sel;
	assign rq      = rfilt_q ? QW'(rprod >> FILT_RSH) : QW'(rprod >> STEP_RSH);
	assign rsub    = quo_q * dv_sel;
	assign rup     = rdiv_q && (rem_q >= DV_W'(dv_sel));
	assign quo_c   = quo_q + QW'(rup);

	// rounded quotient with sign, tilt clamp
	assign qs = sign_q ? -$signed({1'b0, quo_c}) : $signed({1'b0, quo_c});
	always_comb begin
		if (qs > 20'(TILT_LIM)) tilt_c = 17'(TILT_LIM);
		else if (qs < -20'(TILT_LIM)) tilt_c = -17'(TILT_LIM);
		else tilt_c = qs[16:0];
	end

	// integral update
	assign sacc = 30'(esum_q) + $signed(prod_q[29:0]);
	always_comb begin
		if (sacc > 30'(SUM_LIM)) sum_c = 26'(SUM_LIM);
		else if (sacc < -30'(SUM_LIM)) sum_c = -26'(SUM_LIM);
		else sum_c = sacc[25:0];
	end

	assign low_drive = !sat_q && (quo_q < QW'(STOP_LEVEL));
	assign in_range  = (tilt_q > -17'(RANGE_LIM)) && (tilt_q < 17'(RANGE_LIM));

	assign stat.div_done = (dcnt_q == '0);
	assign stat.out_busy = res_valid_q && !result.ready;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gp_q  <= 16'd12544;
			gi_q  <= 16'd51;
			gd_q  <= 16'd90;
			tgt_q <= 17'sd1766;
		end else if (cfg.valid) begin
			unique case (cfg.addr)
				CFG_GAIN_PROP:   gp_q  <= cfg.data[15:0];
				CFG_GAIN_INTEG:  gi_q  <= cfg.data[15:0];
				CFG_GAIN_DERIV:  gd_q  <= cfg.data[15:0];
				CFG_TARGET_TILT: tgt_q <= $signed(cfg.data);
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			ax_q  <= sample.accel_x;
			az_q  <= sample.accel_z;
			gy_q  <= sample.gyro_y;
			ms_q  <= (sample.elapsed_ms == '0) ? 10'd1 : sample.elapsed_ms;
			kms_q <= 20'((sample.elapsed_ms == '0) ? 10'd1 : sample.elapsed_ms) * 20'(K_MILLI);
		end
		unique case (cmd.op)
			OP_PRE: begin
				zero_q <= (ax_q == '0) && (az_q == '0);
				if (x0 < 0) begin
					if (y0 >= 0) begin
						x_q <= y0; y_q <= -x0; z_q <= Z_QUARTER;
					end else begin
						x_q <= -y0; y_q <= x0; z_q <= -Z_QUARTER;
					end
				end else begin
					x_q <= x0; y_q <= y0; z_q <= '0;
				end
			end
			OP_CORD: begin
				if (y_q >= 0) begin
					x_q <= x_q + ys; y_q <= y_q - xs; z_q <= z_q + zt;
				end else begin
					x_q <= x_q - ys; y_q <= y_q + xs; z_q <= z_q - zt;
				end
			end
			OP_ACC: begin
				acc_q  <= zero_q ? '0 : acc_r;
				prod_q <= mul_p[57:0];
			end
			OP_STEP: step_q <= qs[17:0];
			OP_TILT: tilt_q <= tilt_c;
			OP_ERR:  err_q <= 18'(tgt_q) - 18'(tilt_q);
			OP_M1: begin
				diff_q <= 19'(err_q) - 19'(lerr_q);
				prod_q <= mul_p[57:0];
			end
			OP_M2: begin
				sum_q  <= sum_c;
				prod_q <= mul_p[57:0];
			end
			OP_M3, OP_M5, OP_M7: prod_q <= mul_p[57:0];
			OP_M4: begin
				num_q  <= prod_q[56:0];
				prod_q <= mul_p[57:0];
			end
			OP_M6: begin
				num_q  <= num_q + prod_q[56:0];
				prod_q <= mul_p[57:0];
			end
			OP_M8: num_q <= num_q + prod_q[56:0];
			default: ;
		endcase
	end

	// shared divider: reciprocal estimate and remainder fix-up for the fixed divisors,
	// restoring steps (one quotient bit a cycle) for the drive
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else begin
			priority if (cmd.op == OP_SDIV) begin
				rem_q   <= nstep;
				quo_q   <= '0;
				sign_q  <= prod_q[57];
				rdiv_q  <= 1'b1;
				rfilt_q <= 1'b0;
				dcnt_q  <= 5'(RCP_CYCLES);
			end else if (cmd.op == OP_FDIV) begin
				rem_q   <= nfilt;
				quo_q   <= '0;
				sign_q  <= fnum[26];
				rdiv_q  <= 1'b1;
				rfilt_q <= 1'b1;
				dcnt_q  <= 5'(RCP_CYCLES);
			end else if (cmd.op == OP_DDIV) begin
				rem_q  <= nmag;
				dsh_q  <= DV_W'({kms_q, 23'd0});
				quo_q  <= '0;
				sat_q  <= sat_c;
				rdiv_q <= 1'b0;
				dcnt_q <= 5'(DRV_QBITS);
			end else if (dcnt_q != '0) begin
				if (rdiv_q) begin
					if (dcnt_q == 5'(RCP_CYCLES)) quo_q <= rq;
					else rem_q <= rem_q - DV_W'(rsub);
				end else begin
					if (rem_q >= dsh_q) begin
						rem_q <= rem_q - dsh_q;
						quo_q <= {quo_q[QW-2:0], 1'b1};
					end else begin
						quo_q <= {quo_q[QW-2:0], 1'b0};
					end
					dsh_q <= dsh_q >> 1;
				end
				dcnt_q <= dcnt_q - 1'b1;
			end
		end
	end

	// loop state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tilt_est_q  <= '0;
			esum_q      <= '0;
			lerr_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (result.valid && result.ready) res_valid_q <= 1'b0;
			if (cmd.op == OP_FIN && !stat.out_busy) begin
				res_valid_q <= 1'b1;
				angle_q     <= tilt_q;
				tilt_est_q  <= tilt_q;
				lerr_q      <= err_q;
				if (low_drive) begin
					dir_q   <= DIR_STOP;
					speed_q <= '0;
					esum_q  <= sum_q;
				end else if (in_range) begin
					dir_q   <= (num_q > 0) ? DIR_BACK : DIR_FWD;
					speed_q <= sat_q ? SPEED_MAX : quo_q[7:0];
					esum_q  <= sum_q;
				end else begin
					dir_q   <= DIR_STOP;
					speed_q <= '0;
					esum_q  <= '0;
				end
			end
		end
	end

	assign result.valid       = res_valid_q;
	assign result.drive_dir   = dir_q;
	assign result.drive_speed = speed_q;
	assign result.tilt_angle  = angle_q;

	`TBP_ASSERT_ALWAYS(a_tilt_lim, clk, arst_n, tilt_est_q <= 17'(TILT_LIM) && tilt_est_q >= -17'(TILT_LIM), "tilt estimate out of range")
	`TBP_ASSERT_ALWAYS(a_sum_lim, clk, arst_n, esum_q <= 26'(SUM_LIM) && esum_q >= -26'(SUM_LIM), "integral out of range")
	`TBP_ASSERT_ALWAYS(a_stop_speed, clk, arst_n, !res_valid_q || dir_q != DIR_STOP || speed_q == '0, "speed while stopped")
endmodule
`default_nettype wire

// ===== rtl/core/tilt_balance_pid_controller_core.sv =====
// Top level of the tilt balance controller: sequencer plus datapath.
//
// Usage notes:
//  sample : one motion request (accel x/z, gyro y, elapsed ms) per sample.
//  result : one request back per sample: direction, speed, filtered tilt.
//  cfg    : register writes (0 P gain, 1 I gain, 2 D gain, 3 target tilt),
//           always ready; write only while no sample is in flight.
//  Time per sample is set by the cordic loop, the 8-bit serial drive
//           divider and the reciprocal divisions for gyro step and filter.
//  One sample is worked at a time; sample.ready is high only when idle.
//  The result sits in an output register; the next sample is accepted and
//  worked while it waits, and the block holds at its last step until the
//  receiver takes the older result.
//  Reset: tilt estimate, integral and last error clear to zero, gains and
//  target return to their defaults, no result pending.
//  A zero elapsed time counts as 1 ms.
`default_nettype none
module tilt_balance_pid_controller_core #(
	parameter int ATAN_ITERATIONS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	tbp_in_if.sink    sample,
	tbp_out_if.source result,
	tbp_cfg_if.sink   cfg
);
	import tbp_pkg::*;

	tbp_cmd_t  cmd;
	tbp_stat_t stat;

	// sequencer: one step of the sample's work per state
	tbp_ctrl #(
		.ATAN_ITERATIONS(ATAN_ITERATIONS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.stat     (stat),
		.cmd      (cmd)
	);

	// arithmetic, loop state, registers and output stage
	tbp_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat),
		.sample (sample),
		.result (result),
		.cfg    (cfg)
	);
endmodule
`default_nettype wire

// ===== tb/sv/tbp_checker.sv =====
// Checker for the tilt balance controller: predicts each result and compares it.
`default_nettype none
module tbp_checker (
	input  logic clk,
	input  logic arst_n,
	tbp_in_if    smp,
	tbp_out_if   res,
	tbp_cfg_if   cfg,
	output int   fails,
	output int   pending
);
	import tbp_pkg::*;

	localparam int CORDIC_STEPS = 16;

	typedef struct packed {
		logic [1:0]         dir;
		logic [7:0]         speed;
		logic signed [16:0] tilt;
	} drive_t;

	localparam longint ATAN_LUT [24] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

	logic [15:0]        kp, ki, kd;
	logic signed [16:0] setpoint;
	longint             tilt_est, err_sum, prev_err;
	drive_t             drive_q[$];

	function automatic longint rdiv(longint n, longint d);
		if (n >= 0) return (n + d / 2) / d;
		return -((-n + d / 2) / d);
	endfunction

	function automatic longint clampl(longint v, longint lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	// vectoring CORDIC, angle in 1/256 degree
	function automatic longint accel_tilt(longint y, longint x);
		longint z, t, xs, ys;
		z = 0;
		if (x == 0 && y == 0) return 0;
		x = x * 65536;
		y = y * 65536;
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; z = 90 * 65536;
			end else begin
				t = x; x = -y; y = t; z = -90 * 65536;
			end
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x += ys; y -= xs; z += ATAN_LUT[i];
			end else begin
				x -= ys; y += xs; z -= ATAN_LUT[i];
			end
		end
		return rdiv(z, 256);
	endfunction

	// one sample through filter and PID; updates the shadow state
	function automatic drive_t predict_drive(logic signed [15:0] ax, logic signed [15:0] az,
			logic signed [15:0] gy, logic [9:0] ms_in);
		longint ms, acc, stp, tilt, err, sum;
		logic signed [127:0] num, den, mag, w_err, w_sum, w_diff, w_ms;
		drive_t r;
		ms = (ms_in == 0) ? 1 : longint'(ms_in);
		acc = accel_tilt(-longint'(ax), longint'(az));
		stp = rdiv(longint'(gy) * ms * 256, 131000);
		tilt = clampl(rdiv((tilt_est + stp) * 49 + acc, 50), TILT_LIM);
		tilt_est = tilt;
		err = longint'(setpoint) - tilt;
		sum = clampl(err_sum + err * ms, SUM_LIM);
		w_err = err;
		w_sum = sum;
		w_diff = err - prev_err;
		w_ms = ms;
		prev_err = err;
		num = $signed({112'd0, kp}) * w_err * 1000 * w_ms
			+ $signed({112'd0, ki}) * w_sum * w_ms
			+ $signed({112'd0, kd}) * w_diff * 1000000;
		den = 65536000 * w_ms;
		mag = (num < 0) ? -num : num;
		r.tilt = tilt[16:0];
		if (mag < 10 * den) begin
			r.dir = DIR_STOP;
			r.speed = '0;
		end else if (tilt > -RANGE_LIM && tilt < RANGE_LIM) begin
			r.speed = (mag / den > 255) ? SPEED_MAX : 8'(mag / den);
			r.dir = (num > 0) ? DIR_BACK : DIR_FWD;
		end else begin
			r.dir = DIR_STOP;
			r.speed = '0;
			sum = 0;
		end
		err_sum = sum;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		drive_t got, want;
		if (!arst_n) begin
			kp = 16'd12544; ki = 16'd51; kd = 16'd90; setpoint = 17'sd1766;
			tilt_est = 0; err_sum = 0; prev_err = 0;
			fails = 0;
			drive_q.delete();
			pending = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.addr)
					CFG_GAIN_PROP:   kp = cfg.data[15:0];
					CFG_GAIN_INTEG:  ki = cfg.data[15:0];
					CFG_GAIN_DERIV:  kd = cfg.data[15:0];
					CFG_TARGET_TILT: setpoint = cfg.data;
				endcase
			end
			if (res.valid && res.ready) begin
				got = '{res.drive_dir, res.drive_speed, res.tilt_angle};
				if (drive_q.size() == 0) begin
					fails++;
					if (fails <= 10) $display("unexpected result dir=%0d speed=%0d tilt=%0d",
						got.dir, got.speed, got.tilt);
				end else begin
					want = drive_q.pop_front();
					if (got !== want) begin
						fails++;
						if (fails <= 10)
							$display("mismatch: exp dir=%0d speed=%0d tilt=%0d, got dir=%0d speed=%0d tilt=%0d",
								want.dir, want.speed, want.tilt, got.dir, got.speed, got.tilt);
					end
				end
			end
			if (smp.valid && smp.ready)
				drive_q.push_back(predict_drive(smp.accel_x, smp.accel_z, smp.gyro_y,
					smp.elapsed_ms));
			pending = drive_q.size();
		end
	end
endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Testbench top of the tilt balance controller: stimulus, stalls and verdict.
`default_nettype none
module tb_top;
	import tbp_pkg::*;

	logic clk;
	logic arst_n;
	int   fails, pending;
	int   send_idle_pct, stall_pct;
	bit   hold_off;
	bit   stim_done;

	tbp_in_if  smp();
	tbp_out_if res();
	tbp_cfg_if cfg();

	tilt_balance_pid_controller_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (smp),
		.result (res),
		.cfg    (cfg)
	);

	tbp_checker u_chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.smp     (smp),
		.res     (res),
		.cfg     (cfg),
		.fails   (fails),
		.pending (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// receiver side: random stalls, or a solid hold-off when asked
	always @(negedge clk) begin
		if (hold_off)
			res.ready <= 1'b0;
		else
			res.ready <= ($urandom_range(99) >= stall_pct);
	end

	// offer one sample request; random idle cycles ahead of it
	task automatic send_sample(logic signed [15:0] ax, logic signed [15:0] az,
			logic signed [15:0] gy, logic [9:0] ms);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			smp.valid <= 1'b0;
		end
		@(negedge clk);
		smp.valid      <= 1'b1;
		smp.accel_x    <= ax;
		smp.accel_z    <= az;
		smp.gyro_y     <= gy;
		smp.elapsed_ms <= ms;
		do @(posedge clk); while (!smp.ready);
	endtask

	// register write: only once the block has drained, plus its latency
	task automatic write_reg(logic [1:0] idx, logic [16:0] val);
		@(negedge clk);
		smp.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		cfg.valid <= 1'b1;
		cfg.addr  <= idx;
		cfg.data  <= val;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// mostly near-upright samples so the PID stays engaged; some noise
	task automatic random_sample();
		if ($urandom_range(3) != 0)
			send_sample(16'($signed($urandom_range(8000)) - 4000),
				16'($signed($urandom_range(6000)) + 13000),
				16'($signed($urandom_range(4000)) - 2000),
				10'($urandom_range(40)));
		else
			send_sample(16'($urandom), 16'($urandom), 16'($urandom), 10'($urandom));
	endtask

	// long receiver hold-off while the sender keeps offering; fills the block
	initial begin
		hold_off = 1'b0;
		wait (stim_done == 1'b0 && arst_n === 1'b1);
		repeat (3000) @(posedge clk);
		hold_off = 1'b1;
		repeat (600) @(posedge clk);
		hold_off = 1'b0;
	end

	initial begin
		int idle_mode [4][2];
		idle_mode = '{'{0, 0}, '{56, 0}, '{0, 56}, '{7, 7}};
		stim_done = 1'b0;
		send_idle_pct = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		smp.valid = 1'b0; smp.accel_x = '0; smp.accel_z = '0;
		smp.gyro_y = '0; smp.elapsed_ms = '0;
		cfg.valid = 1'b0; cfg.addr = '0; cfg.data = '0;
		res.ready = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: field extremes and the special angles and timings
		send_sample(16'sd0, 16'sd0, 16'sd0, 10'd0);          // both axes zero, zero dt
		send_sample(16'sd0, -16'sd16384, 16'sd0, 10'd10);    // upside down: +180
		send_sample(-16'sd32768, -16'sd32768, -16'sd32768, 10'd1000);
		send_sample(16'sd32767, 16'sd32767, 16'sd32767, 10'd1023);  // dt above range
		send_sample(16'sd32767, -16'sd32768, 16'sd0, 10'd1);
		send_sample(-16'sd32768, 16'sd32767, 16'sd0, 10'd5);
		send_sample(16'sd0, 16'sd16384, 16'sd0, 10'd10);
		send_sample(16'sd0, 16'sd16384, 16'sd0, 10'd10);
		send_sample(-16'sd2000, 16'sd16000, 16'sd100, 10'd10);
		send_sample(16'sd2000, 16'sd16000, -16'sd100, 10'd10);
		send_sample(16'sd0, 16'sd16384, 16'sd32767, 10'd1000); // gyro pushes far over
		send_sample(16'sd0, 16'sd16384, -16'sd32768, 10'd1000);
		send_sample(16'sd500, 16'sd16384, 16'sd0, 10'd0);
		send_sample(16'sd0, 16'sd1, 16'sd0, 10'd20);

		// extremes of every register: gains at maximum then zero, target at both ends
		write_reg(CFG_GAIN_PROP, 17'd65535);
		write_reg(CFG_GAIN_INTEG, 17'd65535);
		write_reg(CFG_GAIN_DERIV, 17'd65535);
		write_reg(CFG_TARGET_TILT, 17'h1_0000);   // most negative 17 bit setpoint
		for (int i = 0; i < 8; i++) random_sample();
		write_reg(CFG_TARGET_TILT, 17'h0_FFFF);
		for (int i = 0; i < 8; i++) random_sample();
		write_reg(CFG_GAIN_PROP, 17'd0);
		write_reg(CFG_GAIN_INTEG, 17'd0);
		write_reg(CFG_GAIN_DERIV, 17'd0);
		write_reg(CFG_TARGET_TILT, 17'(-46080));
		for (int i = 0; i < 8; i++) random_sample();
		write_reg(CFG_TARGET_TILT, 17'd46080);
		for (int i = 0; i < 8; i++) random_sample();

		// random part: phases of idling, with a register setting per phase
		for (int ph = 0; ph < 8; ph++) begin
			send_idle_pct = idle_mode[ph % 4][0];
			stall_pct     = idle_mode[ph % 4][1];
			if (ph % 2 == 0) begin
				write_reg(CFG_GAIN_PROP, 17'($urandom_range(20000)));
				write_reg(CFG_GAIN_INTEG, 17'($urandom_range(400)));
				write_reg(CFG_GAIN_DERIV, 17'($urandom_range(600)));
				write_reg(CFG_TARGET_TILT, 17'($signed($urandom_range(6000)) - 3000));
			end else begin
				write_reg(CFG_GAIN_PROP, 17'($urandom));
				write_reg(CFG_GAIN_INTEG, 17'($urandom));
				write_reg(CFG_GAIN_DERIV, 17'($urandom));
				write_reg(CFG_TARGET_TILT, 17'($urandom));
			end
			for (int i = 0; i < 100; i++) random_sample();
		end
		@(negedge clk);
		smp.valid <= 1'b0;
		stim_done = 1'b1;
		stall_pct = 0;

		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fails == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// watchdog
	initial begin
		#40000000;
		$display("RESULT: ERROR");
		$finish;
	end
endmodule
`default_nettype wire
